### hw/rtl/dh_pkg.sv
// Shared types, constants and table builders for the screened Coulomb pair energy block.
// No dependencies; imported by every module of the block except dh_div.
package dh_pkg;

    localparam int EXP_DEPTH_DEFAULT = 256;
    localparam int QUEUE_DEPTH       = 4;
    localparam int INT_EXP_COUNT     = 32;
    localparam logic [46:0] MAG_LIMIT       = '1;
    localparam logic [31:0] PREFACTOR_RESET = 32'd29205800;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SAME_ATOM = 2'd1,
        ST_ZERO_DIST = 2'd2,
        ST_SATURATED = 2'd3
    } dh_status_t;

    typedef struct packed {
        dh_status_t  status;
        logic        zero_res;
        logic        neg;
        logic [30:0] qmag;
        logic [47:0] x;
        logic [31:0] r;
    } dh_item_t;

    // exp(-f) in Q1.31 for f in Q1.31, truncated Taylor series
    function automatic logic [31:0] exp_entry(input logic [63:0] f);
        logic [63:0] term;
        logic [63:0] sp;
        logic [63:0] sn;
        term = 64'd1 << 31;
        sp   = term;
        sn   = '0;
        for (int n = 1; n < 16; n++) begin
            term = ((term * f) >> 31) / 64'(n);
            if (n[0]) sn = sn + term;
            else sp = sp + term;
        end
        return (sp > sn) ? 32'(sp - sn) : 32'd0;
    endfunction

    // exp(-k) in Q1.31, rounded product chain
    function automatic logic [31:0] int_exp_entry(input int k);
        logic [63:0] e;
        logic [63:0] t;
        e = 64'd1 << 31;
        t = 64'(exp_entry(64'd1 << 31));
        for (int j = 1; j < INT_EXP_COUNT; j++) begin
            if (j <= k) e = (e * t + (64'd1 << 30)) >> 31;
        end
        return e[31:0];
    endfunction

endpackage

### hw/rtl/dh_front.sv
// Front end: accepts pairs, classifies special cases, forms |qa*qb| and kappa*r.
// Depends on dh_pkg.
module dh_front import dh_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [31:0]  kappa,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // first_atom_index, second_atom_index, first_charge,
                                    // second_charge, pair_distance
    output logic         out_valid,
    input  logic         out_ready,
    output dh_item_t     out_item
);

    logic        valid_reg;
    dh_item_t    item_reg;
    dh_item_t    item_next;
    logic [19:0] ia;
    logic [19:0] ib;
    logic signed [15:0] qa;
    logic signed [15:0] qb;
    logic signed [31:0] qq;
    logic [31:0] r;
    logic [63:0] kr;

    assign ia = s_tdata[19:0];
    assign ib = s_tdata[39:20];
    assign qa = signed'(s_tdata[55:40]);
    assign qb = signed'(s_tdata[71:56]);
    assign r  = s_tdata[103:72];
    assign qq = qa * qb;
    assign kr = 64'(kappa) * 64'(r);

    always_comb begin
        item_next.neg  = qq[31];
        item_next.qmag = qq[31] ? 31'(-qq) : 31'(qq);
        item_next.x    = kr[63:16];
        item_next.r    = r;
        if (ia == ib) begin
            item_next.status = ST_SAME_ATOM;
        end else if (r == 32'd0) begin
            item_next.status = ST_ZERO_DIST;
        end else begin
            item_next.status = ST_OK;
        end
        item_next.zero_res = (ia == ib) || (r == 32'd0) || (qq == 32'sd0);
    end

    assign s_tready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

### hw/rtl/dh_fifo.sv
// Short word queue between front and back end.
// Depends on dh_pkg.
module dh_fifo import dh_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  dh_item_t in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output dh_item_t out_item
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    dh_item_t      mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign in_ready  = count_reg != CNT_FULL;
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ((wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? ((rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule

### hw/rtl/dh_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag and sideband.
// No package dependency; instanced by dh_back.
module dh_div #(
    parameter int DVD_W  = 64,
    parameter int DVS_W  = 32,
    parameter int QUOT_W = 47,
    parameter int PAY_W  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  in_dividend,
    input  logic [DVS_W-1:0]  in_divisor,
    input  logic [PAY_W-1:0]  in_payload,
    output logic              out_valid,
    output logic [QUOT_W-1:0] out_quot,
    output logic              out_ovf,
    output logic [DVS_W-1:0]  out_divisor,
    output logic [PAY_W-1:0]  out_payload
);

    logic              valid_reg [QUOT_W+1];
    logic [DVS_W-1:0]  rem_reg   [QUOT_W+1];
    logic [DVS_W-1:0]  rem_next  [QUOT_W+1];
    logic [QUOT_W-1:0] sh_reg    [QUOT_W+1];
    logic [QUOT_W-1:0] sh_next   [QUOT_W+1];
    logic [DVS_W-1:0]  dvs_reg   [QUOT_W+1];
    logic [PAY_W-1:0]  pay_reg   [QUOT_W+1];
    logic              ovf_reg   [QUOT_W+1];
    logic              ovf_next;

    assign ovf_next    = DVS_W'(in_dividend[DVD_W-1:QUOT_W]) >= in_divisor;
    assign rem_next[0] = DVS_W'(in_dividend[DVD_W-1:QUOT_W]);
    assign sh_next[0]  = in_dividend[QUOT_W-1:0];

    for (genvar k = 1; k <= QUOT_W; k++) begin : g_step
        logic [DVS_W:0] trial;
        logic [DVS_W:0] diff;
        logic           ge;
        assign trial      = {rem_reg[k-1], sh_reg[k-1][QUOT_W-1]};
        assign diff       = trial - {1'b0, dvs_reg[k-1]};
        assign ge         = trial >= {1'b0, dvs_reg[k-1]};
        assign rem_next[k] = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        assign sh_next[k]  = {sh_reg[k-1][QUOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QUOT_W; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= QUOT_W; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem_next[0];
            sh_reg[0]  <= sh_next[0];
            dvs_reg[0] <= in_divisor;
            pay_reg[0] <= in_payload;
            ovf_reg[0] <= ovf_next;
            for (int k = 1; k <= QUOT_W; k++) begin
                rem_reg[k] <= rem_next[k];
                sh_reg[k]  <= sh_next[k];
                dvs_reg[k] <= dvs_reg[k-1];
                pay_reg[k] <= pay_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign out_valid   = valid_reg[QUOT_W];
    assign out_quot    = sh_reg[QUOT_W];
    assign out_ovf     = ovf_reg[QUOT_W];
    assign out_divisor = dvs_reg[QUOT_W];
    assign out_payload = pay_reg[QUOT_W];

endmodule

### hw/rtl/dh_back.sv
// Back end: exponential lookup, energy and derivative datapath, output register.
// Depends on dh_pkg and dh_div.
module dh_back import dh_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] kappa,
    input  logic [31:0] prefactor,
    input  logic        in_valid,
    output logic        in_ready,
    input  dh_item_t    in_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // pair_energy, energy_derivative
    output logic [1:0]  m_tuser    // result_status
);

    localparam int AW    = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int POS_W = 32 + AW;
    localparam int QW    = 47;
    localparam logic [AW-1:0] IDX_LAST = AW'(EXP_TABLE_DEPTH - 1);
    localparam logic [AW-1:0] DEPTH_A  = AW'(EXP_TABLE_DEPTH);

    typedef struct packed {
        dh_status_t status;
        logic       zero_res;
        logic       neg;
    } dh_side_t;

    typedef struct packed {
        logic [55:0] t1;
        logic [46:0] emag;
        logic        ovf;
        dh_side_t    side;
    } dh_pay2_t;

    localparam int PAY1_W = $bits(dh_side_t);
    localparam int PAY2_W = $bits(dh_pay2_t);

    logic [31:0] frac_rom [EXP_TABLE_DEPTH+1];
    logic [31:0] int_rom  [INT_EXP_COUNT];

    for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_frac
        localparam logic [63:0] FG = (64'(g) << 31) / EXP_TABLE_DEPTH;
        assign frac_rom[g] = exp_entry(FG);
    end

    for (genvar k = 0; k < INT_EXP_COUNT; k++) begin : g_int
        assign int_rom[k] = int_exp_entry(k);
    end

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign in_ready = en;

    // stage 0
    logic             v0_reg;
    dh_side_t         side0_reg;
    logic [POS_W-1:0] pos0_reg;
    logic [61:0]      m0_reg;
    logic             big0_reg;
    logic [4:0]       n0_reg;
    logic [31:0]      r0_reg;
    // stage 1
    logic             v1_reg;
    dh_side_t         side1_reg;
    logic [31:0]      lo1_reg;
    logic [31:0]      hi1_reg;
    logic [31:0]      w1_reg;
    logic [31:0]      ie1_reg;
    logic             big1_reg;
    logic [61:0]      m1_reg;
    logic [31:0]      r1_reg;
    logic [AW-1:0]    idx1_raw;
    logic [AW-1:0]    idx1_next;
    // stage 2
    logic             v2_reg;
    dh_side_t         side2_reg;
    logic [31:0]      ef2_reg;
    logic [31:0]      ef2_next;
    logic [31:0]      ie2_reg;
    logic             big2_reg;
    logic [61:0]      m2_reg;
    logic [31:0]      r2_reg;
    logic [31:0]      diff2;
    logic [63:0]      prod2;
    // stage 3
    logic             v3_reg;
    dh_side_t         side3_reg;
    logic [31:0]      ex3_reg;
    logic [31:0]      ex3_next;
    logic [63:0]      prod3;
    logic [61:0]      m3_reg;
    logic [31:0]      r3_reg;
    // stage 4
    logic             v4_reg;
    dh_side_t         side4_reg;
    logic [62:0]      ph4_reg;
    logic [62:0]      pl4_full;
    logic [31:0]      pl4_reg;
    logic [31:0]      r4_reg;
    // stage 5
    logic             v5_reg;
    dh_side_t         side5_reg;
    logic [63:0]      a5_reg;
    logic [31:0]      r5_reg;
    // first divider
    logic             d1_valid;
    logic [QW-1:0]    d1_quot;
    logic             d1_ovf;
    logic [31:0]      d1_dvs;
    logic [PAY1_W-1:0] d1_pay;
    // stage 6
    logic             v6_reg;
    dh_side_t         side6_reg;
    logic [54:0]      kh6_reg;
    logic [55:0]      kl6_full;
    logic [31:0]      kl6_reg;
    logic [46:0]      emag6_reg;
    logic             ovf6_reg;
    logic [31:0]      r6_reg;
    // stage 7
    logic             v7_reg;
    dh_pay2_t         pay7_reg;
    dh_pay2_t         pay7_next;
    logic [31:0]      r7_reg;
    // second divider
    logic             d2_valid;
    logic [QW-1:0]    d2_quot;
    logic             d2_ovf;
    logic [31:0]      d2_dvs;
    logic [PAY2_W-1:0] d2_pay_bits;
    dh_pay2_t         d2_pay;
    // output
    logic             m_valid_reg;
    logic [47:0]      m_energy_reg;
    logic [47:0]      m_energy_next;
    logic [47:0]      m_deriv_reg;
    logic [47:0]      m_deriv_next;
    dh_status_t       m_status_reg;
    dh_status_t       m_status_next;
    logic [56:0]      dsum;
    logic [46:0]      emag_f;
    logic [46:0]      dmag_f;
    logic             sat_f;

    always_comb begin
        idx1_raw  = pos0_reg[POS_W-1:32];
        idx1_next = (idx1_raw >= DEPTH_A) ? IDX_LAST : idx1_raw;
        diff2     = (lo1_reg >= hi1_reg) ? (lo1_reg - hi1_reg) : (hi1_reg - lo1_reg);
        prod2     = 64'(diff2) * 64'(w1_reg);
        ef2_next  = (lo1_reg >= hi1_reg) ? (lo1_reg - prod2[63:32]) : (lo1_reg + prod2[63:32]);
        prod3     = 64'(ef2_reg) * 64'(ie2_reg) + (64'd1 << 30);
        ex3_next  = big2_reg ? 32'd0 : prod3[62:31];
        pl4_full  = 63'(m3_reg[30:0]) * 63'(ex3_reg);
        kl6_full  = 56'(kappa) * 56'(d1_quot[23:0]);
        pay7_next.t1   = 56'(kh6_reg) + 56'(kl6_reg);
        pay7_next.emag = emag6_reg;
        pay7_next.ovf  = ovf6_reg;
        pay7_next.side = side6_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= d1_valid;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side0_reg <= '{status: in_item.status, zero_res: in_item.zero_res,
                           neg: in_item.neg};
            pos0_reg  <= POS_W'(in_item.x[31:0]) * POS_W'(EXP_TABLE_DEPTH);
            m0_reg    <= 62'(prefactor) * 62'(in_item.qmag);
            big0_reg  <= |in_item.x[47:37];
            n0_reg    <= in_item.x[36:32];
            r0_reg    <= in_item.r;

            side1_reg <= side0_reg;
            lo1_reg   <= frac_rom[idx1_next];
            hi1_reg   <= frac_rom[AW'(idx1_next + 1'b1)];
            w1_reg    <= pos0_reg[31:0];
            ie1_reg   <= int_rom[n0_reg];
            big1_reg  <= big0_reg;
            m1_reg    <= m0_reg;
            r1_reg    <= r0_reg;

            side2_reg <= side1_reg;
            ef2_reg   <= ef2_next;
            ie2_reg   <= ie1_reg;
            big2_reg  <= big1_reg;
            m2_reg    <= m1_reg;
            r2_reg    <= r1_reg;

            side3_reg <= side2_reg;
            ex3_reg   <= ex3_next;
            m3_reg    <= m2_reg;
            r3_reg    <= r2_reg;

            side4_reg <= side3_reg;
            ph4_reg   <= 63'(m3_reg[61:31]) * 63'(ex3_reg);
            pl4_reg   <= pl4_full[62:31];
            r4_reg    <= r3_reg;

            side5_reg <= side4_reg;
            a5_reg    <= 64'(ph4_reg) + 64'(pl4_reg);
            r5_reg    <= r4_reg;

            side6_reg <= dh_side_t'(d1_pay);
            kh6_reg   <= 55'(kappa) * 55'(d1_quot[46:24]);
            kl6_reg   <= kl6_full[55:24];
            emag6_reg <= d1_quot;
            ovf6_reg  <= d1_ovf;
            r6_reg    <= d1_dvs;

            pay7_reg  <= pay7_next;
            r7_reg    <= r6_reg;
        end
    end

    dh_div #(
        .DVD_W  (64),
        .DVS_W  (32),
        .QUOT_W (QW),
        .PAY_W  (PAY1_W)
    ) u_div_energy (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (v5_reg),
        .in_dividend (a5_reg),
        .in_divisor  (r5_reg),
        .in_payload  (side5_reg),
        .out_valid   (d1_valid),
        .out_quot    (d1_quot),
        .out_ovf     (d1_ovf),
        .out_divisor (d1_dvs),
        .out_payload (d1_pay)
    );

    dh_div #(
        .DVD_W  (71),
        .DVS_W  (32),
        .QUOT_W (QW),
        .PAY_W  (PAY2_W)
    ) u_div_deriv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (v7_reg),
        .in_dividend ({pay7_reg.emag, 24'd0}),
        .in_divisor  (r7_reg),
        .in_payload  (pay7_reg),
        .out_valid   (d2_valid),
        .out_quot    (d2_quot),
        .out_ovf     (d2_ovf),
        .out_divisor (d2_dvs),
        .out_payload (d2_pay_bits)
    );

    assign d2_pay = dh_pay2_t'(d2_pay_bits);

    always_comb begin
        dsum   = 57'(d2_pay.t1) + 57'(d2_quot);
        emag_f = d2_pay.emag;
        dmag_f = dsum[46:0];
        sat_f  = 1'b0;
        if (d2_pay.ovf) begin
            emag_f = MAG_LIMIT;
            dmag_f = MAG_LIMIT;
            sat_f  = 1'b1;
        end else if (d2_ovf || (dsum > 57'(MAG_LIMIT))) begin
            dmag_f = MAG_LIMIT;
            sat_f  = 1'b1;
        end
        if (d2_pay.side.zero_res) begin
            m_energy_next = '0;
            m_deriv_next  = '0;
            m_status_next = d2_pay.side.status;
        end else begin
            m_energy_next = d2_pay.side.neg ? -48'(emag_f) : 48'(emag_f);
            m_deriv_next  = d2_pay.side.neg ? 48'(dmag_f) : -48'(dmag_f);
            m_status_next = sat_f ? ST_SATURATED : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && d2_valid) begin
            m_energy_reg <= m_energy_next;
            m_deriv_reg  <= m_deriv_next;
            m_status_reg <= m_status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_deriv_reg, m_energy_reg};
    assign m_tuser  = m_status_reg;

`ifndef ASSERT_OFF
    a_special_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_SAME_ATOM || m_status_reg == ST_ZERO_DIST))
        |-> (m_energy_reg == '0 && m_deriv_reg == '0))
        else $error("special case word carries a non-zero result");
    a_sat_deriv: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_SATURATED)
        |-> (m_deriv_reg == 48'h7FFF_FFFF_FFFF || m_deriv_reg == 48'h8000_0000_0001))
        else $error("saturated word with unclamped derivative");
`endif

endmodule

### hw/rtl/debye_huckel_pair_energy.sv
// Path: front register, queue, six exponential and product stages, a 48-stage divider, two
// derivative product stages, a second 48-stage divider, output register.
// Throughput: one pair per cycle unless m_tready stalls the back end; set by the
// bit-per-stage dividers, which are fully pipelined.
// Reset: synchronous active-low aresetn clears all valid flags and the queue, kappa to zero
// and the prefactor to its default; the exponential tables are constant logic.
// Depends on dh_pkg, dh_front, dh_fifo, dh_back.
module debye_huckel_pair_energy import dh_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // first_atom_index, second_atom_index, first_charge,
                                    // second_charge, pair_distance
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // pair_energy, energy_derivative
    output logic [1:0]   m_tuser,   // result_status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic {
        CFG_KAPPA     = 1'b0,
        CFG_PREFACTOR = 1'b1
    } dh_cfg_idx_t;

    logic [31:0] kappa_reg;
    logic [31:0] prefactor_reg;
    logic        f_valid;
    logic        f_ready;
    dh_item_t    f_item;
    logic        q_valid;
    logic        q_ready;
    dh_item_t    q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kappa_reg     <= '0;
            prefactor_reg <= PREFACTOR_RESET;
        end else if (cfg_valid) begin
            unique case (dh_cfg_idx_t'(cfg_index))
                CFG_KAPPA: begin
                    kappa_reg <= cfg_data;
                end
                CFG_PREFACTOR: begin
                    prefactor_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    dh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .kappa     (kappa_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    dh_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    dh_back #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .kappa     (kappa_reg),
        .prefactor (prefactor_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### tb/testbench.sv
// Self-checking bench for debye_huckel_pair_energy: directed table, then random pairs under several
// kappa/prefactor settings, with stalls on both streams; results checked by an in-bench predictor.
// Depends on dh_pkg and the block's RTL.
module testbench;
    import dh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [47:0] LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_LIM = 48'h8000_0000_0001;
    localparam logic CFG_KAPPA = 1'b0;
    localparam logic CFG_PREFACTOR = 1'b1;

    typedef struct {
        logic [19:0] ia;
        logic [19:0] ib;
        logic [15:0] qa;
        logic [15:0] qb;
        logic [31:0] r;
    } pair_t;

    typedef struct {
        logic [47:0] energy;
        logic [47:0] deriv;
        dh_status_t  status;
    } energy_t;

    typedef struct {
        pair_t   p;
        bit      known;
        energy_t res;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = 1'b0;
    logic [31:0]  cfg_data = '0;

    longint unsigned frac_exp[0:TABLE_DEPTH];
    longint unsigned int_exp[0:31];
    longint unsigned kappa_q;
    longint unsigned prefactor_q;
    energy_t expected_results[$];
    int mismatches = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int idle_cycles = 0;

    debye_huckel_pair_energy dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void build_exp_tables();
        longint unsigned f, term;
        longint sum;
        for (int i = 0; i <= TABLE_DEPTH; i++) begin
            f = (longint'(i) << 31) / TABLE_DEPTH;
            term = 64'd1 << 31;
            sum = longint'(64'd1 << 31);
            for (int n = 1; n < 16; n++) begin
                term = ((term * f) >> 31) / longint'(n);
                if (n % 2 == 1) sum -= longint'(term);
                else sum += longint'(term);
            end
            frac_exp[i] = (sum < 0) ? 64'd0 : longint'(sum);
        end
        int_exp[0] = 64'd1 << 31;
        for (int n = 1; n < 32; n++)
            int_exp[n] = (int_exp[n-1] * frac_exp[TABLE_DEPTH] + (64'd1 << 30)) >> 31;
    endfunction

    function automatic longint unsigned exp_neg_q31(longint unsigned x);
        longint unsigned n, pos, idx, w, lo, hi, ef;
        n = x >> 32;
        if (n >= 32) return 0;
        pos = (x & 64'hFFFF_FFFF) * TABLE_DEPTH;
        idx = pos >> 32;
        w = pos & 64'hFFFF_FFFF;
        if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
        lo = frac_exp[idx];
        hi = frac_exp[idx+1];
        if (lo >= hi) ef = lo - (((lo - hi) * w) >> 32);
        else ef = lo + (((hi - lo) * w) >> 32);
        return (ef * int_exp[n] + (64'd1 << 30)) >> 31;
    endfunction

    function automatic energy_t screened_energy(pair_t p);
        energy_t res;
        longint qq;
        longint unsigned qmag, ex, m, a, emag, dmag, t1, q, rem, r;
        bit neg;
        bit sat;
        res = '{48'd0, 48'd0, ST_OK};
        r = p.r;
        sat = 1'b0;
        if (p.ia == p.ib) begin
            res.status = ST_SAME_ATOM;
            return res;
        end
        if (r == 0) begin
            res.status = ST_ZERO_DIST;
            return res;
        end
        qq = longint'($signed(p.qa)) * longint'($signed(p.qb));
        if (qq == 0) return res;
        neg = qq < 0;
        qmag = neg ? -qq : qq;
        ex = exp_neg_q31((kappa_q * r) >> 16);
        m = prefactor_q * qmag;
        a = (m >> 31) * ex + (((m & 64'h7FFF_FFFF) * ex) >> 31);
        emag = a / r;
        if (emag > LIM) begin
            emag = LIM;
            dmag = LIM;
            sat = 1'b1;
        end else begin
            t1 = kappa_q * (emag >> 24) + ((kappa_q * (emag & 64'hFF_FFFF)) >> 24);
            q = emag / r;
            rem = emag % r;
            if (q >= (64'd1 << 23)) begin
                dmag = LIM;
                sat = 1'b1;
            end else begin
                dmag = t1 + (q << 24) + ((rem << 24) / r);
                if (dmag > LIM) begin
                    dmag = LIM;
                    sat = 1'b1;
                end
            end
        end
        res.energy = neg ? 48'(-emag) : 48'(emag);
        res.deriv = neg ? 48'(dmag) : 48'(-dmag);
        res.status = sat ? ST_SATURATED : ST_OK;
        return res;
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            m_tready <= 1'b0;
            repeat (400) @(posedge aclk);
            hold_req = 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge aclk) begin
        energy_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tdata[47:0] !== exp_r.energy || m_tdata[95:48] !== exp_r.deriv ||
                    m_tuser !== exp_r.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: E %h/%h dE %h/%h status %0d/%0d (exp/got)",
                                 exp_r.energy, m_tdata[47:0], exp_r.deriv, m_tdata[95:48],
                                 exp_r.status, m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_KAPPA) kappa_q = value;
        else prefactor_q = value;
        @(posedge aclk);
    endtask

    task automatic send_pair(pair_t p, bit known, energy_t res);
        s_tvalid <= 1'b1;
        s_tdata <= {p.r, p.qb, p.qa, p.ib, p.ia};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(known ? res : screened_energy(p));
        if (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic pair_t random_pair();
        pair_t p;
        p.ia = 20'($urandom);
        p.ib = 20'($urandom);
        p.qa = 16'($urandom);
        p.qb = 16'($urandom);
        if ($urandom_range(99) < 80) begin
            if (p.ia == p.ib) p.ib = p.ia + 20'd1;
            p.r = $urandom_range(32'h0040_0000, 32'h1FFF_FFFF);
        end else begin
            p.r = $urandom;
            case ($urandom_range(3))
                0: p.ib = p.ia;
                1: p.r = '0;
                2: p.qa = '0;
                default: ;
            endcase
        end
        return p;
    endfunction

    stim_row_t directed[] = '{
        '{'{20'd5, 20'd5, 16'h1000, 16'h1000, 32'h0100_0000}, 1, '{'0, '0, ST_SAME_ATOM}},
        '{'{20'd0, 20'd0, 16'h1000, 16'h1000, 32'h0}, 1, '{'0, '0, ST_SAME_ATOM}},
        '{'{20'd1, 20'd2, 16'h1000, 16'h1000, 32'h0}, 1, '{'0, '0, ST_ZERO_DIST}},
        '{'{20'd1, 20'd2, 16'h0000, 16'h7FFF, 32'h0100_0000}, 1, '{'0, '0, ST_OK}},
        '{'{20'd1, 20'd2, 16'h1000, 16'h1000, 32'h1}, 1, '{LIM, NEG_LIM, ST_SATURATED}},
        '{'{20'd1, 20'd2, 16'hF000, 16'h1000, 32'h1}, 1, '{NEG_LIM, LIM, ST_SATURATED}},
        '{'{20'd1, 20'd2, 16'h8000, 16'h8000, 32'h0100_0000}, 0, '{'0, '0, ST_OK}},
        '{'{20'd1, 20'd2, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF}, 0, '{'0, '0, ST_OK}},
        '{'{20'hFFFFF, 20'd0, 16'h1000, 16'hF000, 32'h0300_0000}, 0, '{'0, '0, ST_OK}},
        '{'{20'd0, 20'hFFFFF, 16'h0001, 16'h0001, 32'h0100_0000}, 0, '{'0, '0, ST_OK}},
        '{'{20'hAAAAA, 20'h55555, 16'h5555, 16'hAAAA, 32'hAAAA_AAAA}, 0, '{'0, '0, ST_OK}},
        '{'{20'h12345, 20'h54321, 16'h2000, 16'h1800, 32'h0080_0000}, 0, '{'0, '0, ST_OK}}
    };

    logic [31:0] kappa_set[] = '{32'h0100_0000, 32'hFFFF_FFFF, 32'h0, 32'h0080_0000,
                                 32'h0033_3333, 32'h0};
    logic [31:0] prefactor_set[] = '{PREFACTOR_RESET, 32'hFFFF_FFFF, 32'h0, PREFACTOR_RESET,
                                     32'h0100_0000, 32'h0000_0001};

    initial begin
        build_exp_tables();
        kappa_q = 0;
        prefactor_q = PREFACTOR_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) send_pair(directed[i].p, directed[i].known, directed[i].res);
        drain();
        foreach (kappa_set[ph]) begin
            write_reg(CFG_KAPPA, kappa_set[ph]);
            write_reg(CFG_PREFACTOR, prefactor_set[ph]);
            calm = (ph == 3);
            for (int n = 0; n < 250; n++) begin
                if (ph == 1 && n == 60) hold_req = 1'b1;
                if (ph == 2 && n == 120) begin
                    s_tvalid <= 1'b0;
                    wait (expected_results.size() == 0);
                    @(posedge aclk);
                end
                send_pair(random_pair(), 1'b0, '{'0, '0, ST_OK});
            end
            calm = 1'b0;
            drain();
        end
        if (mismatches == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
